@@ hw/rtl/kmp_sr_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_sr_pkg: shared types and constants for the stream replace block
// Register indexes, controller states, datapath commands and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_sr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_RES    = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_BYTES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_REPLACE_BYTES  = 2'd2,
      REG_REPLACE_LENGTH = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      S_BUILD,
      S_IDLE,
      S_MATCH,
      S_REP,
      S_FALL,
      S_FLUSH,
      S_MARK,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_BUILD_STEP,
      CMD_LOAD,
      CMD_MATCH,
      CMD_REP,
      CMD_FALL,
      CMD_FLUSH,
      CMD_MARK,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic pat_write;
      logic build_done;
      logic match_eq;
      logic j_zero;
      logic jn_full;
      logic loop_done;
      logic flush_done;
      logic slot_ok;
      logic fin_ok;
      logic n_zero;
      logic last;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/kmp_sr_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmp_sr_ctrl: sequencing state machine
// Builds the failure table, then walks each text byte through match, fallback,
// replacement, flush, end-marker and finish steps via datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_sr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire kmp_sr_pkg::stat_type stat,
   output kmp_sr_pkg::cmd_type       cmd
);
   import kmp_sr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BUILD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_BUILD: begin
            if (stat.build_done) begin
               state_in = S_IDLE;
            end else begin
               cmd = CMD_BUILD_STEP;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (stat.slot_ok) begin
               cmd = CMD_MATCH;
               if (stat.match_eq) begin
                  state_in = stat.jn_full ? S_REP : S_FLUSH;
               end else begin
                  state_in = stat.j_zero ? S_FLUSH : S_FALL;
               end
            end
         end
         S_REP: begin
            if (stat.loop_done) begin
               state_in = S_FLUSH;
            end else if (stat.slot_ok) begin
               cmd = CMD_REP;
            end
         end
         S_FALL: begin
            if (stat.loop_done) begin
               state_in = S_MATCH;
            end else if (stat.slot_ok) begin
               cmd = CMD_FALL;
            end
         end
         S_FLUSH: begin
            if (!stat.last || stat.flush_done) begin
               state_in = (stat.last && stat.n_zero) ? S_MARK : S_DONE;
            end else if (stat.slot_ok) begin
               cmd = CMD_FLUSH;
            end
         end
         S_MARK: begin
            if (stat.slot_ok) begin
               cmd      = CMD_MARK;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.fin_ok) begin
               cmd      = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_BUILD;
         end
      endcase
      // pattern change restarts the table build
      if (stat.pat_write) begin
         state_in = S_BUILD;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/kmp_sr_dpath.sv @@
// ----------------------------------------------------------------------------
// kmp_sr_dpath: registers, failure table and output staging
// Holds configuration, the KMP failure table, match counters, a pending
// result slot (so the last result of a byte can be flagged) and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_sr_dpath #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [kmp_sr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kmp_sr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [kmp_sr_pkg::BYTE_W-1:0]         req_text_byte,
   input  wire logic                                  req_text_last,
   input  wire kmp_sr_pkg::cmd_type                   cmd,
   output kmp_sr_pkg::stat_type                       stat,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output logic [kmp_sr_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                       rsp_byte_valid,
   output logic                                       rsp_run_last,
   output logic                                       rsp_text_end
);
   import kmp_sr_pkg::*;

   localparam int PAT_W  = PATTERN_MAX * BYTE_W;
   localparam int REP_W  = REPLACE_MAX * BYTE_W;
   localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

   // configuration
   logic [PAT_W-1:0]  pat_ff, pat_in;
   logic [CNT_W-1:0]  plen_ff, plen_in;
   logic [REP_W-1:0]  rep_ff, rep_in;
   logic [CNT_W-1:0]  rlen_ff, rlen_in;

   // failure table and build pointers
   logic [CNT_W-1:0]  tbl_ff [PATTERN_MAX];
   logic [CNT_W-1:0]  tbl_in [PATTERN_MAX];
   logic [CNT_W-1:0]  bi_ff, bi_in;
   logic [CNT_W-1:0]  bk_ff, bk_in;

   // per-transaction state
   logic [CNT_W-1:0]  mcount_ff, mcount_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [BYTE_W-1:0] c_ff, c_in;
   logic              last_ff, last_in;

   // pending and output slots
   logic              pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic              pend_bv_ff, pend_bv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_rl_ff, rsp_rl_in;
   logic              rsp_te_ff, rsp_te_in;

   logic [CNT_W-1:0]  m_eff;
   logic [CNT_W-1:0]  r_eff;
   logic [CNT_W-1:0]  jn;
   logic [CNT_W-1:0]  tbl_addr;
   logic [CNT_W-1:0]  tbl_rd;
   logic [CNT_W-1:0]  f_eff;
   logic [BYTE_W-1:0] pat_j, pat_i, pat_bi, pat_bk, rep_i;
   logic              out_free;
   logic              pat_write;
   logic              emit_req;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_bv;
   logic              do_emit;
   logic              fin;
   logic              load_out;
   logic              load_rl;
   logic              load_te;

   always_comb begin
      if (plen_ff == '0) begin
         m_eff = CNT_W'(1);
      end else if (plen_ff > CNT_W'(PATTERN_MAX)) begin
         m_eff = CNT_W'(PATTERN_MAX);
      end else begin
         m_eff = plen_ff;
      end
      if (rlen_ff > CNT_W'(REPLACE_MAX)) begin
         r_eff = CNT_W'(REPLACE_MAX);
      end else begin
         r_eff = rlen_ff;
      end
   end

   assign pat_j  = pat_ff[BYTE_W*j_ff[PIDX_W-1:0]  +: BYTE_W];
   assign pat_i  = pat_ff[BYTE_W*i_ff[PIDX_W-1:0]  +: BYTE_W];
   assign pat_bi = pat_ff[BYTE_W*bi_ff[PIDX_W-1:0] +: BYTE_W];
   assign pat_bk = pat_ff[BYTE_W*bk_ff[PIDX_W-1:0] +: BYTE_W];
   assign rep_i  = rep_ff[BYTE_W*i_ff[RIDX_W-1:0]  +: BYTE_W];

   assign jn       = j_ff + CNT_W'(1);
   assign tbl_addr = (cmd == CMD_BUILD_STEP) ? (bk_ff - CNT_W'(1)) : (j_ff - CNT_W'(1));
   assign tbl_rd   = tbl_ff[tbl_addr[PIDX_W-1:0]];
   assign f_eff    = (tbl_rd >= j_ff) ? '0 : tbl_rd;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pat_write = csr_wr_en && ((csr_index == REG_PATTERN_BYTES) ||
                                    (csr_index == REG_PATTERN_LENGTH));

   assign stat.pat_write  = pat_write;
   assign stat.build_done = (bi_ff >= m_eff);
   assign stat.match_eq   = (c_ff == pat_j);
   assign stat.j_zero     = (j_ff == '0);
   assign stat.jn_full    = (jn == m_eff);
   assign stat.loop_done  = (i_ff >= lim_ff);
   assign stat.flush_done = (i_ff >= j_ff);
   assign stat.slot_ok    = (n_ff >= CNT_W'(MAX_RES)) || !pend_valid_ff || out_free;
   assign stat.fin_ok     = !pend_valid_ff || out_free;
   assign stat.n_zero     = (n_ff == '0);
   assign stat.last       = last_ff;

   always_comb begin
      pat_in        = pat_ff;
      plen_in       = plen_ff;
      rep_in        = rep_ff;
      rlen_in       = rlen_ff;
      tbl_in        = tbl_ff;
      bi_in         = bi_ff;
      bk_in         = bk_ff;
      mcount_in     = mcount_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      lim_in        = lim_ff;
      n_in          = n_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_bv_in    = pend_bv_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_rl_in     = rsp_rl_ff;
      rsp_te_in     = rsp_te_ff;
      emit_req      = 1'b0;
      emit_byte     = '0;
      emit_bv       = 1'b1;
      fin           = 1'b0;
      load_out      = 1'b0;
      load_rl       = 1'b0;
      load_te       = 1'b0;

      unique case (cmd) inside
         CMD_NONE: begin
         end
         CMD_BUILD_STEP: begin
            if (pat_bi == pat_bk) begin
               tbl_in[bi_ff[PIDX_W-1:0]] = bk_ff + CNT_W'(1);
               bk_in = bk_ff + CNT_W'(1);
               bi_in = bi_ff + CNT_W'(1);
            end else if (bk_ff == '0) begin
               tbl_in[bi_ff[PIDX_W-1:0]] = '0;
               bi_in = bi_ff + CNT_W'(1);
            end else begin
               bk_in = tbl_rd;
            end
         end
         CMD_LOAD: begin
            c_in    = req_text_byte;
            last_in = req_text_last;
            j_in    = (mcount_ff >= m_eff) ? '0 : mcount_ff;
            n_in    = '0;
         end
         CMD_MATCH: begin
            i_in = '0;
            if (c_ff == pat_j) begin
               if (jn == m_eff) begin
                  j_in   = '0;
                  lim_in = r_eff;
               end else begin
                  j_in = jn;
               end
            end else if (j_ff == '0) begin
               emit_req  = 1'b1;
               emit_byte = c_ff;
            end else begin
               j_in   = f_eff;
               lim_in = j_ff - f_eff;
            end
         end
         CMD_REP: begin
            emit_req  = 1'b1;
            emit_byte = rep_i;
            i_in      = i_ff + CNT_W'(1);
         end
         CMD_FALL, CMD_FLUSH: begin
            emit_req  = 1'b1;
            emit_byte = pat_i;
            i_in      = i_ff + CNT_W'(1);
         end
         CMD_MARK: begin
            emit_req  = 1'b1;
            emit_byte = '0;
            emit_bv   = 1'b0;
         end
         CMD_FINISH: begin
            fin       = 1'b1;
            mcount_in = last_ff ? '0 : j_ff;
         end
         default: begin
         end
      endcase

      // results past the cap are dropped
      do_emit = emit_req && (n_ff < CNT_W'(MAX_RES));
      if (do_emit) begin
         n_in          = n_ff + CNT_W'(1);
         pend_valid_in = 1'b1;
         pend_byte_in  = emit_byte;
         pend_bv_in    = emit_bv;
         if (pend_valid_ff) begin
            load_out = 1'b1;
         end
      end
      if (fin && pend_valid_ff) begin
         load_out      = 1'b1;
         load_rl       = 1'b1;
         load_te       = last_ff;
         pend_valid_in = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = pend_byte_ff;
         rsp_bv_in    = pend_bv_ff;
         rsp_rl_in    = load_rl;
         rsp_te_in    = load_te;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PATTERN_BYTES:  pat_in  = csr_wdata[PAT_W-1:0];
            REG_PATTERN_LENGTH: plen_in = csr_wdata[CNT_W-1:0];
            REG_REPLACE_BYTES:  rep_in  = csr_wdata[REP_W-1:0];
            REG_REPLACE_LENGTH: rlen_in = csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
      // new pattern: drop held match, restart table build
      if (pat_write) begin
         mcount_in     = '0;
         pend_valid_in = 1'b0;
         bi_in         = CNT_W'(1);
         bk_in         = '0;
         for (int e = 0; e < PATTERN_MAX; e++) begin
            tbl_in[e] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff        <= '0;
         plen_ff       <= CNT_W'(1);
         rep_ff        <= '0;
         rlen_ff       <= '0;
         bi_ff         <= CNT_W'(1);
         bk_ff         <= '0;
         mcount_ff     <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int e = 0; e < PATTERN_MAX; e++) begin
            tbl_ff[e] <= '0;
         end
      end else begin
         pat_ff        <= pat_in;
         plen_ff       <= plen_in;
         rep_ff        <= rep_in;
         rlen_ff       <= rlen_in;
         bi_ff         <= bi_in;
         bk_ff         <= bk_in;
         mcount_ff     <= mcount_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tbl_ff        <= tbl_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      i_ff         <= i_in;
      lim_ff       <= lim_in;
      c_ff         <= c_in;
      last_ff      <= last_in;
      pend_byte_ff <= pend_byte_in;
      pend_bv_ff   <= pend_bv_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_rl_ff    <= rsp_rl_in;
      rsp_te_ff    <= rsp_te_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_run_last   = rsp_rl_ff;
   assign rsp_text_end   = rsp_te_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("output register overwritten while stalled");

   a_fin_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH && stat.fin_ok) |=> !pend_valid_ff)
      else $error("pending result left after transaction end");

   a_pend_count: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (n_ff != '0))
      else $error("pending result without a result count");

endmodule

`default_nettype wire

@@ hw/rtl/kmp_stream_replace_top.sv @@
// ----------------------------------------------------------------------------
// kmp_stream_replace_top: streaming KMP substring replacement
// Rewrites a byte stream, replacing each leftmost non-overlapping pattern
// occurrence with a replacement string.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per transaction (req_text_last ends a text).
//   rsp_* carries 0 to 8 result transactions per text byte; rsp_run_last
//   flags the last one of a byte, rsp_text_end the last one of a text. A
//   final byte that yields nothing gives one bare end marker.
//   csr_* writes pattern/replacement registers while the block is idle.
// Sequence:
//   A straight-through byte passes the match, flush and finish states before
//   the next byte is taken. A full match emits the replacement bytes in S_REP,
//   a fallback releases pattern bytes in S_FALL, the final flush emits the
//   held bytes, a bare end marker uses S_MARK and rsp_stall holds the block.
//   Results are held one deep: each goes out as the next is made, the last at
//   the end of its byte. A pattern write rebuilds the table.
// Reset (synchronous) loads register defaults, clears the held match and
// builds the table; req_stall is high while the table builds. A stalled rsp_*
// holds; the block keeps working until its pending slot fills, then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_stream_replace_top #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [kmp_sr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kmp_sr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [kmp_sr_pkg::BYTE_W-1:0]         req_text_byte,
   input  wire logic                                  req_text_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [kmp_sr_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                       rsp_byte_valid,
   output logic                                       rsp_run_last,
   output logic                                       rsp_text_end
);
   import kmp_sr_pkg::*;

   stat_type stat;
   cmd_type  cmd;

   kmp_sr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   kmp_sr_dpath #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_text_byte  (req_text_byte),
      .req_text_last  (req_text_last),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_end   (rsp_text_end)
   );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for kmp_stream_replace_top
// Feeds text bytes and register settings to the stream replace block. A
// scoreboard predicts the rewritten byte stream and checks every rsp
// transaction field by field. A short directed script comes first, then
// random texts under several pattern/replacement settings and idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import kmp_sr_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int BUILD_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 50;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_end;
   } out_txn_type;

   typedef struct {
      bit          is_reg;
      reg_idx_type idx;
      logic [63:0] wdata;
      logic [7:0]  tbyte;
      bit          tlast;
      bit          typed;
      bit          typed_one;
      out_txn_type typed_res;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_text_byte = '0;
   logic                  req_text_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_byte_valid;
   logic                  rsp_run_last;
   logic                  rsp_text_end;

   kmp_stream_replace_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scoreboard state: shadow registers, held match count, failure table
   logic [63:0] pat_reg;
   logic [3:0]  pat_len;
   logic [63:0] rep_reg;
   logic [3:0]  rep_len;
   int          held_count;
   int          fail_tab [8];
   out_txn_type step_out [$];
   out_txn_type pending_out [$];
   out_txn_type oldest;

   int fail_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int sent_in_phase;

   function automatic int pat_len_eff();
      int m;
      m = pat_len;
      if (m == 0) m = 1;
      if (m > 8) m = 8;
      return m;
   endfunction

   function automatic int rep_len_eff();
      return (rep_len > 8) ? 8 : int'(rep_len);
   endfunction

   function automatic logic [7:0] pat_byte(int i);
      return pat_reg[8*(i%8) +: 8];
   endfunction

   function automatic void rebuild_fail_table();
      int m, k, i;
      m = pat_len_eff();
      k = 0;
      i = 1;
      for (int x = 0; x < 8; x++) fail_tab[x] = 0;
      while (i < m) begin
         if (pat_byte(i) == pat_byte(k)) begin
            k++;
            fail_tab[i] = k;
            i++;
         end else if (k == 0) begin
            fail_tab[i] = 0;
            i++;
         end else begin
            k = fail_tab[(k-1)%8];
         end
      end
   endfunction

   function automatic void set_register(reg_idx_type idx, logic [63:0] d);
      case (idx)
         REG_PATTERN_BYTES: begin
            pat_reg = d;
            held_count = 0;
            rebuild_fail_table();
         end
         REG_PATTERN_LENGTH: begin
            pat_len = d[3:0];
            held_count = 0;
            rebuild_fail_table();
         end
         REG_REPLACE_BYTES: rep_reg = d;
         REG_REPLACE_LENGTH: rep_len = d[3:0];
         default: ;
      endcase
   endfunction

   function automatic void put_out(logic [7:0] b, logic v);
      out_txn_type t;
      t = '{b, v, 1'b0, 1'b0};
      if (step_out.size() < MAX_RES) step_out = {step_out, t};
   endfunction

   // expected rewritten bytes for one text byte, left in step_out
   function automatic void rewrite_byte(logic [7:0] c, bit last);
      int m, j, f, n;
      bit busy;
      step_out.delete();
      m = pat_len_eff();
      j = (held_count >= m) ? 0 : held_count;
      busy = 1'b1;
      while (busy) begin
         if (c == pat_byte(j)) begin
            j++;
            if (j == m) begin
               for (int i = 0; i < rep_len_eff(); i++) put_out(rep_reg[8*i +: 8], 1'b1);
               j = 0;
            end
            busy = 1'b0;
         end else if (j == 0) begin
            put_out(c, 1'b1);
            busy = 1'b0;
         end else begin
            f = fail_tab[(j-1)%8];
            if (f >= j) f = 0;
            for (int i = 0; i < j - f; i++) put_out(pat_byte(i), 1'b1);
            j = f;
         end
      end
      if (last) begin
         for (int i = 0; i < j; i++) put_out(pat_byte(i), 1'b1);
         j = 0;
         if (step_out.size() == 0) put_out(8'h00, 1'b0);
      end
      held_count = j;
      n = step_out.size();
      if (n > 0) begin
         step_out[n-1].run_last = 1'b1;
         if (last) step_out[n-1].text_end = 1'b1;
      end
   endfunction

   function automatic script_row_type text_row(logic [7:0] b, bit l);
      script_row_type r;
      r.is_reg = 1'b0;
      r.idx = REG_PATTERN_BYTES;
      r.wdata = '0;
      r.tbyte = b;
      r.tlast = l;
      r.typed = 1'b0;
      r.typed_one = 1'b0;
      r.typed_res = '0;
      return r;
   endfunction

   function automatic script_row_type reg_row(reg_idx_type idx, logic [63:0] d);
      script_row_type r;
      r = text_row(8'h00, 1'b0);
      r.is_reg = 1'b1;
      r.idx = idx;
      r.wdata = d;
      return r;
   endfunction

   function automatic script_row_type typed_row(logic [7:0] b, bit l, bit one,
                                                out_txn_type res);
      script_row_type r;
      r = text_row(b, l);
      r.typed = 1'b1;
      r.typed_one = one;
      r.typed_res = res;
      return r;
   endfunction

   task automatic drive_byte(script_row_type row);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= row.tbyte;
      req_text_last <= row.tlast;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rewrite_byte(row.tbyte, row.tlast);
      if (row.typed) begin
         if (row.typed_one) pending_out = {pending_out, row.typed_res};
      end else begin
         foreach (step_out[i]) pending_out = {pending_out, step_out[i]};
      end
   endtask

   task automatic send_text(logic [7:0] b);
      drive_byte(text_row(b, $urandom_range(9) == 0));
      sent_in_phase++;
   endtask

   // drain results, then give a byte that produced nothing time to finish
   task automatic quiet_down();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [63:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      set_register(idx, d);
      repeat (BUILD_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual byte %0h valid %b",
                     $time, rsp_out_byte, rsp_byte_valid);
            fail_count++;
         end else begin
            oldest = pending_out.pop_front();
            check_field("out_byte", oldest.out_byte, rsp_out_byte);
            check_field("byte_valid", oldest.byte_valid, rsp_byte_valid);
            check_field("run_last", oldest.run_last, rsp_run_last);
            check_field("text_end", oldest.text_end, rsp_text_end);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type script [$];
      logic [7:0]  alph [3];
      logic [63:0] pbytes;
      logic [3:0]  plen;
      logic [3:0]  rlen;
      int          n;
      int          sel;

      pat_reg = '0;
      pat_len = 4'd1;
      rep_reg = '0;
      rep_len = 4'd0;
      held_count = 0;
      rebuild_fail_table();

      // reset state: pattern is one 00 byte, replacement empty
      script = {script, typed_row(8'h00, 1'b0, 1'b0, '0)};
      script = {script, typed_row(8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0})};
      script = {script, typed_row(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1})};
      // pattern AAB -> YZ, fallback with nonzero failure entry and final flush
      script = {script, reg_row(REG_PATTERN_BYTES, 64'h0000_0000_0042_4141)};
      script = {script, reg_row(REG_PATTERN_LENGTH, 64'd3)};
      script = {script, reg_row(REG_REPLACE_BYTES, 64'h0000_0000_0000_5A59)};
      script = {script, reg_row(REG_REPLACE_LENGTH, 64'd2)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h42, 1'b0)};
      script = {script, text_row(8'h43, 1'b0)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h41, 1'b1)};
      // held partial match dropped by a length write; zero length acts as one
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, reg_row(REG_PATTERN_LENGTH, 64'd0)};
      script = {script, text_row(8'h41, 1'b0)};
      script = {script, text_row(8'h42, 1'b1)};
      // oversized lengths clamp to eight, all-ones pattern
      script = {script, reg_row(REG_PATTERN_BYTES, '1)};
      script = {script, reg_row(REG_PATTERN_LENGTH, 64'd15)};
      script = {script, reg_row(REG_REPLACE_BYTES, 64'h0123_4567_89AB_CDEF)};
      script = {script, reg_row(REG_REPLACE_LENGTH, 64'd15)};
      for (int k = 0; k < 8; k++) script = {script, text_row(8'hFF, 1'b0)};
      script = {script, text_row(8'hFF, 1'b0)};
      script = {script, text_row(8'hFF, 1'b0)};
      script = {script, text_row(8'h00, 1'b1)};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_reg) begin
            quiet_down();
            write_reg(script[k].idx, script[k].wdata);
         end else begin
            drive_byte(script[k]);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         quiet_down();
         for (int k = 0; k < 3; k++) alph[k] = $urandom_range(255);
         for (int k = 0; k < 8; k++) pbytes[8*k +: 8] = alph[$urandom_range(2)];
         case (phase)
            0: begin
               plen = 4'd1;
               rlen = 4'd0;
            end
            1: begin
               plen = 4'd8;
               rlen = 4'd8;
            end
            2: begin
               plen = 4'd0;
               rlen = 4'd15;
            end
            3: begin
               plen = 4'd12;
               rlen = 4'd1;
            end
            default: begin
               plen = $urandom_range(15);
               rlen = $urandom_range(15);
            end
         endcase
         write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
         write_reg(REG_REPLACE_LENGTH, {60'd0, rlen});
         write_reg(REG_PATTERN_BYTES, pbytes);
         write_reg(REG_PATTERN_LENGTH, {60'd0, plen});

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 51;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 51;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct = 10;
            end
         endcase
         if (phase == 4) hold_req++;

         sent_in_phase = 0;
         while (sent_in_phase < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
               // whole pattern or a broken prefix of it
               n = pat_len_eff();
               if ($urandom_range(1) == 1) n = $urandom_range(n, 1);
               for (int k = 0; k < n; k++) send_text(pat_reg[8*k +: 8]);
            end else if (sel < 85) begin
               n = $urandom_range(6, 1);
               for (int k = 0; k < n; k++) send_text(alph[$urandom_range(2)]);
            end else begin
               send_text($urandom_range(255));
            end
         end
      end

      quiet_down();
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/kmp_sr_pkg.sv
hw/rtl/kmp_sr_ctrl.sv
hw/rtl/kmp_sr_dpath.sv
hw/rtl/kmp_stream_replace_top.sv
test/tb_top.sv
